FILE: design/szsd_pkg.sv
package szsd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int DEV_W      = 25;
  localparam int Z_W        = 16;
  localparam int CNT_W      = 7;
  localparam int SUM_W      = 31;
  localparam int SQ_W       = 54;
  localparam int MSQ_W      = 47;
  localparam int ZN_W       = 33;
  localparam int VAR_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int DCNT_W     = 6;
  localparam int THZ_W      = 16;
  localparam int THD_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_DEV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_NEG  = 3'd4;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MULX = 11'b00000000010,
    S_MULO = 11'b00000000100,
    S_SEL  = 11'b00000001000,
    S_DIVS = 11'b00000010000,
    S_DIVQ = 11'b00000100000,
    S_MULM = 11'b00001000000,
    S_VAR  = 11'b00010000000,
    S_SQRT = 11'b00100000000,
    S_DIVZ = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

endpackage

FILE: design/sliding_window_zscore_spike_detect_top.sv
// channel   signals                               direction
// in        in_valid, in_stall, sample            word in
// out       out_valid, out_stall, spike, window_full, base_mean,
//           base_deviation, deviation, zscore     word out
// cfg       cfg_write, cfg_index, cfg_data        register write
// one word at a time through a shared restoring divider and a radix-2 square root
// full baseline: sum divide (31 quotient bits), mean-square divide (54 bits), root (24 bits), z divide (33 bits)
// fewer than two stored samples or disabled: no divide and no root
// rst is synchronous, clears control, counters, sums and the config registers; the ring is not cleared
// in_stall is high from accept until the result is loaded into the output register
module sliding_window_zscore_spike_detect_top
  import szsd_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        spike,
  output logic                        window_full,
  output logic signed [SAMPLE_W-1:0]  base_mean,
  output logic [SAMPLE_W-1:0]         base_deviation,
  output logic signed [DEV_W-1:0]     deviation,
  output logic signed [Z_W-1:0]       zscore
);

  localparam int MAX_WINDOW = DEF_MAX_WINDOW;
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  state_t state;

  logic                       enable;
  logic [CNT_W-1:0]           window_size;
  logic [THZ_W-1:0]           threshold_z;
  logic [THD_W-1:0]           threshold_delta;
  logic                       detect_negative;

  logic [SAMPLE_W-1:0]        ring [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] old_q;
  logic [CNT_W-1:0]           fill_count;
  logic [SLOT_W-1:0]          write_slot;
  logic signed [SUM_W-1:0]    window_sum;
  logic [SQ_W-1:0]            window_square_sum;

  logic signed [SAMPLE_W-1:0] x;
  logic signed [SAMPLE_W-1:0] mean;
  logic [ROOT_W-1:0]          sd;
  logic [ZN_W-1:0]            zmag;
  logic [MSQ_W-1:0]           msq;
  logic [MSQ_W-1:0]           xsq;
  logic [MSQ_W-1:0]           osq;
  logic signed [VAR_W-1:0]    prod;
  logic                       sum_neg;

  logic [SQ_W-1:0]            dnum;
  logic [ROOT_W-1:0]          drem;
  logic [ROOT_W-1:0]          ddiv;
  logic [DCNT_W-1:0]          dcnt;

  logic [VAR_W-1:0]           srad;
  logic [ROOT_W+1:0]          srem;
  logic [ROOT_W-1:0]          sroot;

  logic signed [VAR_W-1:0]    mul_op;
  logic [ROOT_W:0]            rem_sh;
  logic                       d_ge;
  logic [ROOT_W-1:0]          rem_next;
  logic [ROOT_W+3:0]          s_sh;
  logic [ROOT_W+3:0]          s_tr;
  logic                       s_ge;
  logic [ROOT_W+1:0]          srem_next;
  logic [ROOT_W-1:0]          sroot_next;
  logic signed [DEV_W-1:0]    delta_w;
  logic [DEV_W-1:0]           abs_delta;
  logic [SUM_W-1:0]           abs_sum;
  logic signed [VAR_W+7:0]    var_s;
  logic [VAR_W-1:0]           var_c;
  logic                       full;
  logic signed [DEV_W-1:0]    dev;
  logic                       zneg;
  logic                       cond;
  logic signed [Z_W-1:0]      zsat;
  logic [CNT_W:0]             slot_inc;
  logic                       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (state)
      S_MULX:  mul_op = VAR_W'(x);
      S_MULO:  mul_op = VAR_W'(old_q);
      default: mul_op = VAR_W'(mean);
    endcase
  end

  assign rem_sh   = {drem, dnum[SQ_W-1]};
  assign d_ge     = rem_sh >= {1'b0, ddiv};
  assign rem_next = d_ge ? ROOT_W'(rem_sh - {1'b0, ddiv}) : rem_sh[ROOT_W-1:0];

  assign s_sh       = {srem, srad[VAR_W-1 -: 2]};
  assign s_tr       = {2'b00, sroot, 2'b01};
  assign s_ge       = s_sh >= s_tr;
  assign srem_next  = s_ge ? (ROOT_W+2)'(s_sh - s_tr) : s_sh[ROOT_W+1:0];
  assign sroot_next = {sroot[ROOT_W-2:0], s_ge};

  assign delta_w   = DEV_W'(x) - DEV_W'(mean);
  assign abs_delta = delta_w[DEV_W-1] ? DEV_W'(-delta_w) : DEV_W'(delta_w);
  assign abs_sum   = window_sum[SUM_W-1] ? SUM_W'(-window_sum) : SUM_W'(window_sum);
  assign var_s     = $signed({9'd0, msq}) - (VAR_W+8)'(prod);
  assign var_c     = var_s[VAR_W+7] ? '0 : var_s[VAR_W-1:0];

  assign full = fill_count >= window_size;
  assign dev  = (enable && fill_count != '0) ? delta_w : '0;
  assign zneg = dev[DEV_W-1];

  always_comb begin
    if (!zneg) begin
      zsat = (zmag > ZN_W'(32767)) ? 16'sh7fff : Z_W'(zmag);
    end else begin
      zsat = (zmag > ZN_W'(32768)) ? 16'sh8000 : Z_W'(-zmag);
    end
  end

  always_comb begin
    cond = 1'b0;
    if (threshold_delta != '0) begin
      if (!dev[DEV_W-1] && DEV_W'(dev) >= DEV_W'(threshold_delta)) begin
        cond = 1'b1;
      end
      if (detect_negative && dev[DEV_W-1] && abs_delta >= DEV_W'(threshold_delta)) begin
        cond = 1'b1;
      end
    end
    if (threshold_z != '0 && (!zneg || detect_negative) && zmag >= ZN_W'(threshold_z)) begin
      cond = 1'b1;
    end
  end

  assign slot_inc = (CNT_W+1)'(write_slot) + (CNT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      old_q <= ring[write_slot];
    end
    if (state == S_FIN && out_free && enable) begin
      ring[write_slot] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      enable            <= 1'b0;
      window_size       <= CNT_W'(1);
      threshold_z       <= '0;
      threshold_delta   <= '0;
      detect_negative   <= 1'b0;
      fill_count        <= '0;
      write_slot        <= '0;
      window_sum        <= '0;
      window_square_sum <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ENABLE: begin
            enable            <= cfg_data[0];
            fill_count        <= '0;
            write_slot        <= '0;
            window_sum        <= '0;
            window_square_sum <= '0;
          end
          REG_WINDOW_SIZE: begin
            if (cfg_data[CNT_W-1:0] == '0) begin
              window_size <= CNT_W'(1);
            end else if (int'(cfg_data[CNT_W-1:0]) > MAX_WINDOW) begin
              window_size <= CNT_W'(MAX_WINDOW);
            end else begin
              window_size <= cfg_data[CNT_W-1:0];
            end
            fill_count        <= '0;
            write_slot        <= '0;
            window_sum        <= '0;
            window_square_sum <= '0;
          end
          REG_THRESH_Z:   threshold_z     <= cfg_data[THZ_W-1:0];
          REG_THRESH_DEV: threshold_delta <= cfg_data[THD_W-1:0];
          REG_DETECT_NEG: detect_negative <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= SAMPLE_W'($signed(sample[SAMPLE_BITS-1:0]));
            mean  <= '0;
            sd    <= '0;
            zmag  <= '0;
            state <= enable ? S_MULX : S_FIN;
          end
        end
        S_MULX: begin
          prod  <= mul_op * mul_op;
          state <= S_MULO;
        end
        S_MULO: begin
          xsq   <= MSQ_W'(prod);
          prod  <= mul_op * mul_op;
          state <= S_SEL;
        end
        S_SEL: begin
          osq <= MSQ_W'(prod);
          if (fill_count >= CNT_W'(2)) begin
            sum_neg <= window_sum[SUM_W-1];
            dnum    <= {abs_sum, {(SQ_W-SUM_W){1'b0}}};
            drem    <= '0;
            ddiv    <= ROOT_W'(fill_count);
            dcnt    <= DCNT_W'(SUM_W);
            state   <= S_DIVS;
          end else begin
            if (fill_count != '0) begin
              mean <= SAMPLE_W'(window_sum);
            end
            state <= S_FIN;
          end
        end
        S_DIVS: begin
          dnum <= {dnum[SQ_W-2:0], d_ge};
          drem <= rem_next;
          dcnt <= dcnt - DCNT_W'(1);
          if (dcnt == DCNT_W'(1)) begin
            mean  <= sum_neg ? SAMPLE_W'(-{dnum[SAMPLE_W-2:0], d_ge})
                             : SAMPLE_W'({dnum[SAMPLE_W-2:0], d_ge});
            dnum  <= window_square_sum;
            drem  <= '0;
            dcnt  <= DCNT_W'(SQ_W);
            state <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          dnum <= {dnum[SQ_W-2:0], d_ge};
          drem <= rem_next;
          dcnt <= dcnt - DCNT_W'(1);
          if (dcnt == DCNT_W'(1)) begin
            msq   <= {dnum[MSQ_W-2:0], d_ge};
            state <= S_MULM;
          end
        end
        S_MULM: begin
          prod  <= mul_op * mul_op;
          state <= S_VAR;
        end
        S_VAR: begin
          srad  <= var_c;
          srem  <= '0;
          sroot <= '0;
          dcnt  <= DCNT_W'(ROOT_W);
          state <= S_SQRT;
        end
        S_SQRT: begin
          srad  <= {srad[VAR_W-3:0], 2'b00};
          srem  <= srem_next;
          sroot <= sroot_next;
          dcnt  <= dcnt - DCNT_W'(1);
          if (dcnt == DCNT_W'(1)) begin
            sd <= sroot_next;
            if (sroot_next != '0) begin
              dnum  <= {abs_delta, 8'd0, {(SQ_W-ZN_W){1'b0}}};
              drem  <= '0;
              ddiv  <= sroot_next;
              dcnt  <= DCNT_W'(ZN_W);
              state <= S_DIVZ;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_DIVZ: begin
          dnum <= {dnum[SQ_W-2:0], d_ge};
          drem <= rem_next;
          dcnt <= dcnt - DCNT_W'(1);
          if (dcnt == DCNT_W'(1)) begin
            zmag  <= {dnum[ZN_W-2:0], d_ge};
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            spike          <= enable && full && cond;
            window_full    <= enable && full;
            base_mean      <= mean;
            base_deviation <= sd;
            deviation      <= dev;
            zscore         <= zsat;
            if (enable) begin
              if (!full) begin
                window_sum        <= window_sum + SUM_W'(x);
                window_square_sum <= window_square_sum + SQ_W'(xsq);
                fill_count        <= fill_count + CNT_W'(1);
              end else begin
                window_sum        <= window_sum + SUM_W'(x) - SUM_W'(old_q);
                window_square_sum <= window_square_sum + SQ_W'(xsq) - SQ_W'(osq);
              end
              if (slot_inc >= {1'b0, window_size}) begin
                write_slot <= '0;
              end else begin
                write_slot <= SLOT_W'(slot_inc);
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= window_size)
    else $error("fill count exceeds window size");

  a_slot_bounded: assert property (@(posedge clk) disable iff (rst)
    (CNT_W+1)'(write_slot) < {1'b0, window_size})
    else $error("write slot outside window");

  a_spike_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!spike || window_full))
    else $error("spike without full window");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> !in_stall)
    else $error("block did not return to idle after delivering a word");

endmodule

FILE: dv/sliding_window_zscore_spike_detect_top_tb.sv
module sliding_window_zscore_spike_detect_top_tb;
  import szsd_pkg::*;

  localparam int WIN_MAX     = DEF_MAX_WINDOW;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic                spike;
    logic                full;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] sd;
    logic [DEV_W-1:0]    dev;
    logic [Z_W-1:0]      z;
  } spike_word_t;

  class spike_scoreboard;
    bit                   en;
    int                   wsize;
    longint               thz;
    longint               thd;
    bit                   neg;
    longint               ring [WIN_MAX];
    int                   fill;
    int                   slot;
    longint               sum;
    longint               sqsum;
    spike_word_t          expected_q[$];
    int                   errors;

    function new();
      en = 0;
      wsize = 1;
      thz = 0;
      thd = 0;
      neg = 0;
      errors = 0;
      clear_window();
    endfunction

    function void clear_window();
      fill = 0;
      slot = 0;
      sum = 0;
      sqsum = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int w;
      case (idx)
        REG_ENABLE: begin
          en = data[0];
          clear_window();
        end
        REG_WINDOW_SIZE: begin
          w = data[6:0];
          if (w == 0) w = 1;
          if (w > WIN_MAX) w = WIN_MAX;
          wsize = w;
          clear_window();
        end
        REG_THRESH_Z: thz = data[THZ_W-1:0];
        REG_THRESH_DEV: thd = data[THD_W-1:0];
        REG_DETECT_NEG: neg = data[0];
        default: ;
      endcase
    endfunction

    function longint int_sqrt(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      longint x;
      longint mean;
      longint msq;
      longint vr;
      longint sd;
      longint dl;
      longint zq;
      longint zo;
      longint dc;
      longint zc;
      bit cond;
      bit full;
      spike_word_t e;
      x = s;
      mean = 0;
      sd = 0;
      dl = 0;
      zq = 0;
      cond = 0;
      if (!en) begin
        e = '{1'b0, 1'b0, '0, '0, '0, '0};
        expected_q.push_back(e);
        return;
      end
      if (fill >= 2) begin
        msq = sqsum / fill;
        mean = sum / fill;
        vr = msq - mean * mean;
        if (vr < 0) vr = 0;
        sd = int_sqrt(vr);
        dl = x - mean;
        if (sd != 0) zq = (dl * 256) / sd;
        dc = (neg && dl < 0) ? -dl : dl;
        zc = (neg && zq < 0) ? -zq : zq;
        if (thz != 0 && zc >= thz) cond = 1;
        if (thd != 0 && dc >= thd) cond = 1;
      end else if (fill == 1) begin
        mean = sum;
        dl = x - mean;
        dc = (neg && dl < 0) ? -dl : dl;
        if (thd != 0 && dc >= thd) cond = 1;
      end
      zo = zq;
      if (zo > 32767) zo = 32767;
      if (zo < -32768) zo = -32768;
      full = (fill >= wsize);
      if (!full) cond = 0;
      if (fill < wsize) begin
        sum += x;
        sqsum += x * x;
        fill++;
      end else begin
        sum += x - ring[slot];
        sqsum += x * x - ring[slot] * ring[slot];
      end
      ring[slot] = x;
      slot++;
      if (slot >= wsize) slot = 0;
      e.spike = cond;
      e.full = full;
      e.mean = mean[SAMPLE_W-1:0];
      e.sd = sd[SAMPLE_W-1:0];
      e.dev = dl[DEV_W-1:0];
      e.z = zo[Z_W-1:0];
      expected_q.push_back(e);
    endfunction

    function void compare(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(spike_word_t got);
      spike_word_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result word: expected none actual mean %0h", $time,
                 got.mean);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("spike", e.spike, got.spike);
      compare("window_full", e.full, got.full);
      compare("base_mean", e.mean, got.mean);
      compare("base_deviation", e.sd, got.sd);
      compare("deviation", e.dev, got.dev);
      compare("zscore", e.z, got.z);
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        cfg_write;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        out_valid;
  logic                        out_stall;
  logic                        spike;
  logic                        window_full;
  logic signed [SAMPLE_W-1:0]  base_mean;
  logic [SAMPLE_W-1:0]         base_deviation;
  logic signed [DEV_W-1:0]     deviation;
  logic signed [Z_W-1:0]       zscore;

  spike_scoreboard sb;
  bit  idle_en;
  int  hold_req;
  int  cycles;
  int  base_level;

  sliding_window_zscore_spike_detect_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .spike          (spike),
    .window_full    (window_full),
    .base_mean      (base_mean),
    .base_deviation (base_deviation),
    .deviation      (deviation),
    .zscore         (zscore)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    spike_word_t got;
    if (!rst && out_valid && !out_stall) begin
      got.spike = spike;
      got.full = window_full;
      got.mean = base_mean;
      got.sd = base_deviation;
      got.dev = deviation;
      got.z = zscore;
      sb.check_result(got);
    end
  end

  // receiver side: long hold on request, short random bursts while idle_en is set
  initial begin
    int burst;
    out_stall = 0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_stall = 1;
        hold_req--;
      end else if (burst > 0) begin
        out_stall = 1;
        burst--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall = 1;
        burst = $urandom_range(0, 2);
      end else begin
        out_stall = 0;
      end
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 0;
  endtask

  task automatic send(input logic signed [SAMPLE_W-1:0] s);
    @(negedge clk);
    in_valid = 1;
    sample = s;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_sample(s);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 0;
      sample = SAMPLE_W'($urandom);
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(input bit en, input int ws, input int tz, input int td, input bit ng);
    write_cfg(REG_ENABLE, CFG_DATA_W'(en));
    write_cfg(REG_WINDOW_SIZE, CFG_DATA_W'(ws));
    write_cfg(REG_THRESH_Z, CFG_DATA_W'(tz));
    write_cfg(REG_THRESH_DEV, CFG_DATA_W'(td));
    write_cfg(REG_DETECT_NEG, CFG_DATA_W'(ng));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return 24'sh800000;
        1: return 24'sh7fffff;
        2: return 24'sh000000;
        default: return 24'shffffff;
      endcase
    end else if (r < 30) begin
      return SAMPLE_W'($urandom);
    end else if (r < 36) begin
      return SAMPLE_W'(base_level + ($urandom_range(0, 1) ? 1 : -1) *
                       $urandom_range(200, 4000));
    end
    return SAMPLE_W'(base_level + $urandom_range(0, 64) - 32);
  endfunction

  function automatic int pick_window();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return WIN_MAX;
      3: return $urandom_range(WIN_MAX + 1, 127);
      4: return 2;
      default: return $urandom_range(2, 24);
    endcase
  endfunction

  function automatic int pick_thz();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(256, 1200);
    endcase
  endfunction

  function automatic int pick_thd();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 8388607;
      2: return $urandom_range(0, 8388607);
      default: return $urandom_range(50, 3000);
    endcase
  endfunction

  initial begin
    sb = new();
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    sample = '0;
    idle_en = 0;
    hold_req = 0;
    base_level = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // disabled after reset
    send(24'sh7fffff);
    send(24'sh800000);
    drain();

    // directed: empty, single and full baselines, flat window, extremes
    setup(1, 2, 256, 10, 1);
    send(24'sh000000);
    send(24'sh7fffff);
    send(24'sh800000);
    send(24'sh000005);
    send(24'sh000005);
    send(24'sh000005);
    send(24'sh000006);
    send(24'sh800000);
    send(24'sh7fffff);
    send(24'sh7fffff);
    drain();
    setup(1, 0, 65535, 8388607, 0);
    send(24'sh800000);
    send(24'sh7fffff);
    send(24'sh800000);
    send(24'shfffff0);
    drain();
    setup(1, 127, 0, 0, 1);
    for (int i = 0; i < 8; i++) send(i[0] ? 24'sh7fffff : 24'sh800000);
    drain();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      idle_en = (ph % 3 != 2) && (ph < 10);
      base_level = $urandom_range(0, 1) ? $urandom_range(0, 400000) :
                   -$urandom_range(0, 400000);
      setup($urandom_range(0, 7) != 0, pick_window(), pick_thz(), pick_thd(),
            $urandom_range(0, 1));
      for (int k = 0; k < 170; k++) begin
        if (ph == 1 && k == 40) hold_req = 300;
        send(pick_sample());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
